FILE: design/pth_pkg.sv
// shared types and constants of the pointer tracking hash table
// no dependencies; used by every other file of the block
`default_nettype none

package pth_pkg;

    // table geometry and field widths
    localparam int TABLE_SLOTS_DEFAULT = 4096;
    localparam int KEY_W               = 64;
    localparam int BYTES_W             = 48;
    localparam int DEV_W               = 4;
    localparam int LIVE_W              = 13;

    // hash constants: golden-ratio multiplier split into 32-bit halves
    localparam logic [31:0] GOLDEN_LO  = 32'h7F4A_7C15;
    localparam logic [31:0] GOLDEN_HI  = 32'h9E37_79B9;
    localparam int          FOLD_SHIFT = 33;
    localparam int          SLOT_SHIFT = 44;

    // reserved key codes
    localparam logic [KEY_W-1:0] KEY_EMPTY = 64'd0;
    localparam logic [KEY_W-1:0] KEY_TOMB  = 64'd1;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_DUP      = 3'd1,
        STATUS_FULL     = 3'd2,
        STATUS_NOTFOUND = 3'd3,
        STATUS_RESERVED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        HP_IDLE,
        HP_LOW,
        HP_CROSS_A,
        HP_CROSS_B,
        HP_SUM
    } hash_phase_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [KEY_W-1:0]   key_address;
        logic [BYTES_W-1:0] alloc_bytes;
        logic [DEV_W-1:0]   device_number;
    } pth_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [BYTES_W-1:0] removed_bytes;
        logic [DEV_W-1:0]   removed_device;
        logic [LIVE_W-1:0]  live_entries;
    } pth_out_t;

    // write request into the slot memories
    typedef struct packed {
        logic               we_key;
        logic               we_data;
        logic [KEY_W-1:0]   key;
        logic [BYTES_W-1:0] bytes;
        logic [DEV_W-1:0]   device;
    } pth_wr_t;

endpackage

`default_nettype wire

FILE: design/pth_hash.sv
// home slot hash: fold, 64-bit golden multiply on one shared 32x32 multiplier, slot select
// depends on pth_pkg
`default_nettype none

module pth_hash #(
    parameter int TABLE_SLOTS = pth_pkg::TABLE_SLOTS_DEFAULT,
    parameter int AW          = $clog2(TABLE_SLOTS)
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [pth_pkg::KEY_W-1:0] key,
    output logic                         done,
    output logic [AW-1:0]                home
);

    localparam logic [AW-1:0] SLOT_MASK = AW'(TABLE_SLOTS - 1);
    localparam int            HI_OFS    = pth_pkg::SLOT_SHIFT - 32;

    pth_pkg::hash_phase_t phase_reg, phase_next;
    logic [63:0] fold_reg, fold_next;
    logic [63:0] p0_reg, p0_next;
    logic [31:0] c1_reg, c1_next;
    logic [31:0] c2_reg, c2_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [31:0] sum_hi;

    // shared multiplier
    assign prod = 64'(mul_a) * 64'(mul_b);

    // upper word of the product modulo 2^64
    assign sum_hi = p0_reg[63:32] + c1_reg + c2_reg;

    // phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pth_pkg::HP_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // operand and partial product registers
    always_ff @(posedge aclk) begin
        fold_reg <= fold_next;
        p0_reg   <= p0_next;
        c1_reg   <= c1_next;
        c2_reg   <= c2_next;
    end

    // sequencing and operand select
    always_comb begin
        phase_next = phase_reg;
        fold_next  = fold_reg;
        p0_next    = p0_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        mul_a      = fold_reg[31:0];
        mul_b      = pth_pkg::GOLDEN_LO;
        done       = 1'b0;
        home       = sum_hi[HI_OFS +: AW] & SLOT_MASK;
        case (phase_reg)
            pth_pkg::HP_IDLE: begin
                if (start) begin
                    fold_next  = key ^ (key >> pth_pkg::FOLD_SHIFT);
                    phase_next = pth_pkg::HP_LOW;
                end
            end
            pth_pkg::HP_LOW: begin
                p0_next    = prod;
                phase_next = pth_pkg::HP_CROSS_A;
            end
            pth_pkg::HP_CROSS_A: begin
                mul_b      = pth_pkg::GOLDEN_HI;
                c1_next    = prod[31:0];
                phase_next = pth_pkg::HP_CROSS_B;
            end
            pth_pkg::HP_CROSS_B: begin
                mul_a      = fold_reg[63:32];
                c2_next    = prod[31:0];
                phase_next = pth_pkg::HP_SUM;
            end
            pth_pkg::HP_SUM: begin
                done       = 1'b1;
                phase_next = pth_pkg::HP_IDLE;
            end
            default: begin
                phase_next = pth_pkg::HP_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/pth_slot_mem.sv
// slot storage: key memory and size/device memory, one read and one write port each
// depends on pth_pkg
`default_nettype none

module pth_slot_mem #(
    parameter int TABLE_SLOTS = pth_pkg::TABLE_SLOTS_DEFAULT,
    parameter int AW          = $clog2(TABLE_SLOTS)
) (
    input  wire logic                      aclk,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire pth_pkg::pth_wr_t          wr,
    output logic [pth_pkg::KEY_W-1:0]      rd_key,
    output logic [pth_pkg::BYTES_W-1:0]    rd_bytes,
    output logic [pth_pkg::DEV_W-1:0]      rd_dev
);

    localparam int DATA_W = pth_pkg::BYTES_W + pth_pkg::DEV_W;

    logic [pth_pkg::KEY_W-1:0] key_mem [TABLE_SLOTS];
    logic [DATA_W-1:0]         data_mem [TABLE_SLOTS];

    // key memory
    always_ff @(posedge aclk) begin
        if (wr.we_key) begin
            key_mem[wr_addr] <= wr.key;
        end
        if (rd_en) begin
            rd_key <= key_mem[rd_addr];
        end
    end

    // size and device memory
    always_ff @(posedge aclk) begin
        if (wr.we_data) begin
            data_mem[wr_addr] <= {wr.bytes, wr.device};
        end
        if (rd_en) begin
            {rd_bytes, rd_dev} <= data_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/pointer_tracking_hash_table.sv
// Allocation tracker: an open-addressed table keyed by a 64-bit address, linear probing with
// tombstones, one request at a time. An insert or remove first computes the home-slot hash
// on one shared 32x32 multiplier (steps HP_LOW, HP_CROSS_A, HP_CROSS_B, HP_SUM), then reads
// the key memory one slot per cycle, up to TABLE_SLOTS probes. A reserved key or an unused
// kind goes straight to the result. Clear sweeps the key memory one slot per cycle. After
// reset the same sweep runs with s_ready low. Results sit in an output register, so a new
// request is taken while one waits.
// depends on pth_pkg, pth_hash, pth_slot_mem
`default_nettype none

module pointer_tracking_hash_table #(
    parameter int TABLE_SLOTS = pth_pkg::TABLE_SLOTS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pth_pkg::pth_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pth_pkg::pth_out_t      m_data
);

    localparam int            AW        = $clog2(TABLE_SLOTS);
    localparam int            CW        = $clog2(TABLE_SLOTS + 1);
    localparam logic [AW-1:0] SLOT_MASK = AW'(TABLE_SLOTS - 1);
    localparam logic [AW-1:0] SLOT_LAST = AW'(TABLE_SLOTS - 1);

    pth_pkg::state_t   state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [CW-1:0]     live_reg, live_next;
    logic              m_valid_reg, m_valid_next;
    pth_pkg::pth_in_t  op_reg, op_next;
    pth_pkg::pth_out_t res_reg, res_next;
    pth_pkg::pth_out_t out_reg, out_next;
    logic [AW-1:0]     home_reg, home_next;
    logic [AW-1:0]     chk_reg, chk_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;

    logic                         hash_start;
    logic                         hash_done;
    logic [AW-1:0]                hash_home;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    pth_pkg::pth_wr_t             wr;
    logic [pth_pkg::KEY_W-1:0]    rd_key;
    logic [pth_pkg::BYTES_W-1:0]  rd_bytes;
    logic [pth_pkg::DEV_W-1:0]    rd_dev;
    logic                         key_match;
    logic                         key_empty;
    logic                         key_tomb;
    logic                         key_reserved;

    pth_hash #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .AW          (AW)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (s_data.key_address),
        .done    (hash_done),
        .home    (hash_home)
    );

    pth_slot_mem #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .AW          (AW)
    ) u_mem (
        .aclk     (aclk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr       (wr),
        .rd_key   (rd_key),
        .rd_bytes (rd_bytes),
        .rd_dev   (rd_dev)
    );

    assign s_ready = (state_reg == pth_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // slot classification of the key just read, and reserved check of the incoming key
    assign key_match    = (rd_key == op_reg.key_address);
    assign key_empty    = (rd_key == pth_pkg::KEY_EMPTY);
    assign key_tomb     = (rd_key == pth_pkg::KEY_TOMB);
    assign key_reserved = (s_data.key_address == pth_pkg::KEY_EMPTY) ||
                          (s_data.key_address == pth_pkg::KEY_TOMB);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pth_pkg::ST_INIT;
            sweep_reg   <= '0;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
        home_reg   <= home_next;
        chk_reg    <= chk_next;
        rd_idx_reg <= rd_idx_next;
    end

    // request sequencer; the table is touched by one request at a time, and an insert's or
    // remove's single write comes after its last read, so no read ever meets a pending write
    always_comb begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        live_next    = live_reg;
        m_valid_next = m_valid_reg && !m_ready;
        op_next      = op_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        home_next    = home_reg;
        chk_next     = chk_reg;
        hash_start   = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = (home_reg + chk_reg + AW'(1)) & SLOT_MASK;
        wr_addr      = rd_idx_reg;
        wr.we_key    = 1'b0;
        wr.we_data   = 1'b0;
        wr.key       = op_reg.key_address;
        wr.bytes     = op_reg.alloc_bytes;
        wr.device    = op_reg.device_number;

        case (state_reg)
            // clearing pass after reset and for clear requests
            pth_pkg::ST_INIT, pth_pkg::ST_CLEAR: begin
                wr.we_key  = 1'b1;
                wr.key     = pth_pkg::KEY_EMPTY;
                wr_addr    = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == SLOT_LAST) begin
                    sweep_next = '0;
                    state_next = (state_reg == pth_pkg::ST_INIT) ? pth_pkg::ST_IDLE
                                                                 : pth_pkg::ST_RESULT;
                end
            end

            // take a request
            pth_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next                 = s_data;
                    res_next.status         = pth_pkg::STATUS_OK;
                    res_next.removed_bytes  = '0;
                    res_next.removed_device = '0;
                    res_next.live_entries   = pth_pkg::LIVE_W'(live_reg);
                    case (s_data.kind)
                        pth_pkg::KIND_CLEAR: begin
                            live_next  = '0;
                            sweep_next = '0;
                            state_next = pth_pkg::ST_CLEAR;
                        end
                        pth_pkg::KIND_INSERT, pth_pkg::KIND_REMOVE: begin
                            if (key_reserved) begin
                                res_next.status = pth_pkg::STATUS_RESERVED;
                                state_next      = pth_pkg::ST_RESULT;
                            end else begin
                                hash_start = 1'b1;
                                state_next = pth_pkg::ST_HASH;
                            end
                        end
                        default: begin
                            state_next = pth_pkg::ST_RESULT;
                        end
                    endcase
                end
            end

            // wait for the home slot, then read it
            pth_pkg::ST_HASH: begin
                if (hash_done) begin
                    rd_en      = 1'b1;
                    rd_addr    = hash_home;
                    home_next  = hash_home;
                    chk_next   = '0;
                    state_next = pth_pkg::ST_PROBE;
                end
            end

            // check one slot per cycle, reading the next one when the walk goes on
            pth_pkg::ST_PROBE: begin
                state_next = pth_pkg::ST_RESULT;
                case (op_reg.kind)
                    pth_pkg::KIND_INSERT: begin
                        if (key_match) begin
                            res_next.status = pth_pkg::STATUS_DUP;
                        end else if (key_empty || key_tomb) begin
                            wr.we_key             = 1'b1;
                            wr.we_data            = 1'b1;
                            live_next             = live_reg + CW'(1);
                            res_next.live_entries = pth_pkg::LIVE_W'(live_next);
                        end else if (chk_reg == SLOT_LAST) begin
                            res_next.status = pth_pkg::STATUS_FULL;
                        end else begin
                            rd_en      = 1'b1;
                            chk_next   = chk_reg + AW'(1);
                            state_next = pth_pkg::ST_PROBE;
                        end
                    end
                    pth_pkg::KIND_REMOVE: begin
                        if (key_empty) begin
                            res_next.status = pth_pkg::STATUS_NOTFOUND;
                        end else if (key_match) begin
                            wr.we_key               = 1'b1;
                            wr.key                  = pth_pkg::KEY_TOMB;
                            res_next.removed_bytes  = rd_bytes;
                            res_next.removed_device = rd_dev;
                            if (live_reg != '0) begin
                                live_next = live_reg - CW'(1);
                            end
                            res_next.live_entries   = pth_pkg::LIVE_W'(live_next);
                        end else if (chk_reg == SLOT_LAST) begin
                            res_next.status = pth_pkg::STATUS_NOTFOUND;
                        end else begin
                            rd_en      = 1'b1;
                            chk_next   = chk_reg + AW'(1);
                            state_next = pth_pkg::ST_PROBE;
                        end
                    end
                    default: begin
                        state_next = pth_pkg::ST_RESULT;
                    end
                endcase
            end

            // hand the result to the output register once it is free
            pth_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = pth_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = pth_pkg::ST_IDLE;
            end
        endcase
    end

    // address of the slot whose data comes back next cycle
    assign rd_idx_next = rd_en ? rd_addr : rd_idx_reg;

endmodule

`default_nettype wire

FILE: design/pth_checker.sv
// port-level checks of the pointer tracking hash table, bound to the top level
// depends on pth_pkg and pointer_tracking_hash_table
`default_nettype none

module pth_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire pth_pkg::pth_out_t m_data
);

    // the clearing pass after reset holds off requests
    a_reset_not_ready: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken right after reset");

    // one request at a time: an accepted request closes the input side
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in work");

    // only a successful remove returns stored size and device
    a_removed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != pth_pkg::STATUS_OK) |->
            (m_data.removed_bytes == '0) && (m_data.removed_device == '0))
        else $error("removed fields set on a failed request");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

bind pointer_tracking_hash_table pth_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
